// ----- src/beam_extrapolate_window_average_assert.svh -----
`ifndef BEAM_EXTRAPOLATE_WINDOW_AVERAGE_ASSERT_SVH
`define BEAM_EXTRAPOLATE_WINDOW_AVERAGE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BEWA_AP_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define BEWA_AP_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bewa_pkg.sv -----
package bewa_pkg;

  // Fixed field widths, axis count and value count
  localparam int DEPTH_W  = 7;
  localparam int FILL_W   = 7;
  localparam int NUM_AXES = 3;
  localparam int NUM_VAL  = 6;

  // Sequencer states
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MUL  = 10'b00_0000_0010,
    S_PREP = 10'b00_0000_0100,
    S_DIVS = 10'b00_0000_1000,
    S_DIVW = 10'b00_0001_0000,
    S_POST = 10'b00_0010_0000,
    S_RD   = 10'b00_0100_0000,
    S_WR   = 10'b00_1000_0000,
    S_SUM  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

endpackage

// ----- src/bewa_if.sv -----
// Sample item channel
interface bewa_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic                kind;
  logic signed [W-1:0] first_x;
  logic signed [W-1:0] first_y;
  logic signed [W-1:0] first_z;
  logic signed [W-1:0] second_x;
  logic signed [W-1:0] second_y;
  logic signed [W-1:0] second_z;
  modport source (output valid, kind, first_x, first_y, first_z,
                  second_x, second_y, second_z, input ready);
  modport sink   (input valid, kind, first_x, first_y, first_z,
                  second_x, second_y, second_z, output ready);
endinterface

// Result item channel
interface bewa_out_if #(parameter int W = 32);
  logic                           valid;
  logic                           ready;
  logic signed [W-1:0]            target_x;
  logic signed [W-1:0]            target_y;
  logic signed [W-1:0]            target_z;
  logic signed [W-1:0]            slope_x;
  logic signed [W-1:0]            slope_y;
  logic signed [W-1:0]            slope_z;
  logic                           degenerate;
  logic [bewa_pkg::FILL_W-1:0]    fill_count;
  modport source (output valid, target_x, target_y, target_z, slope_x, slope_y,
                  slope_z, degenerate, fill_count, input ready);
  modport sink   (input valid, target_x, target_y, target_z, slope_x, slope_y,
                  slope_z, degenerate, fill_count, output ready);
endinterface

// Window depth write channel
interface bewa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bewa_pkg::DEPTH_W-1:0] window_depth;
  modport source (output valid, window_depth, input ready);
  modport sink   (input valid, window_depth, output ready);
endinterface

// ----- src/bewa_div.sv -----
// Restoring divider, one quotient bit per cycle, W+2 quotient bits.
// Flags overflow when the quotient would not fit in W+2 bits.
module bewa_div #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2*W-1:0] dividend,
  input  logic [W:0]     divisor,
  output logic           done,
  output logic           ovf,
  output logic [W+1:0]   quo
);

  localparam int QW = W + 2;
  localparam int CW = $clog2(QW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W:0]    rem_r;
  logic [QW-1:0] bits_r;
  logic [QW-1:0] q_r;
  logic          ovf_r;

  logic [W-3:0]  upper;
  logic [W+1:0]  trial;
  logic          ge;

  assign upper = dividend[2*W-1:QW];
  assign trial = {rem_r, bits_r[QW-1]};
  assign ge    = (trial >= {1'b0, divisor});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      ovf_r  <= ({3'b000, upper} >= divisor);
      rem_r  <= {3'b000, upper};
      bits_r <= dividend[QW-1:0];
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? (W+1)'(trial - {1'b0, divisor}) : trial[W:0];
      bits_r <= {bits_r[QW-2:0], 1'b0};
      q_r    <= {q_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign ovf  = ovf_r;
  assign quo  = q_r;

endmodule

// ----- src/beam_extrapolate_window_average.sv -----
// A pass-through item runs three serial extrapolation divisions before its result is valid;
//   windowed adds ring read, ring write, six sum updates and six mean divisions; equal z
//   skips the extrapolation. Items are taken only in idle, one at a time, as the one serial
//   divider (a quotient bit per cycle) serves all divisions; an unaccepted result holds the
//   next one back, while the next item may still enter.
// Reset: control, window sums, slot and full flag clear; ring contents stay undefined.
`include "beam_extrapolate_window_average_assert.svh"

module beam_extrapolate_window_average #(
  parameter int MAX_WINDOW  = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  bewa_cfg_if.sink    cfg_ch,
  bewa_in_if.sink     in_ch,
  bewa_out_if.source  out_ch
);

  localparam int W    = COORD_WIDTH;
  localparam int SLW  = $clog2(MAX_WINDOW);
  localparam int CNTW = $clog2(MAX_WINDOW + 1);
  localparam int SW   = W + SLW;
  localparam int XW   = W + 4;
  localparam int RW   = W * bewa_pkg::NUM_VAL;
  localparam int FW   = bewa_pkg::FILL_W;
  localparam logic [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] sat_w(input logic [XW-1:0] v);
    logic signed [XW-1:0] sv;
    sv = $signed(v);
    if (sv > $signed({4'b0000, CMAX}))      sat_w = CMAX;
    else if (sv < $signed({4'b1111, CMIN})) sat_w = CMIN;
    else                                    sat_w = v[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
    mag_w = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  bewa_pkg::state_t state_r;
  logic [2:0]             k_r;
  logic                   avg_r;
  logic [bewa_pkg::DEPTH_W-1:0] depth_r;
  logic [SLW-1:0]         wslot_r;
  logic                   full_r;
  logic                   out_valid_r;
  logic signed [SW-1:0]   sums_r [bewa_pkg::NUM_VAL];

  logic [W-1:0]           p2_r   [bewa_pkg::NUM_AXES];
  logic [W-1:0]           val_r  [bewa_pkg::NUM_VAL];
  logic [W-1:0]           res_r  [bewa_pkg::NUM_VAL];
  logic [W-1:0]           out_r  [bewa_pkg::NUM_VAL];
  logic [W:0]             den_r;
  logic                   degen_r;
  logic                   out_degen_r;
  logic [bewa_pkg::FILL_W-1:0] out_fill_r;
  logic [2*W-1:0]         prod_r;
  logic [2*W-1:0]         dvd_r;
  logic [W:0]             dsr_r;
  logic                   neg_r;
  logic [CNTW-1:0]        cnt_r;
  logic [SLW-1:0]         slot_r;
  logic                   was_full_r;
  logic [RW-1:0]          rd_q_r;
  logic [RW-1:0]          ring_mem [MAX_WINDOW];

  // item fields as arrays
  logic [W-1:0] p1_in [bewa_pkg::NUM_AXES];
  logic [W-1:0] p2_in [bewa_pkg::NUM_AXES];
  assign p1_in[0] = in_ch.first_x;
  assign p1_in[1] = in_ch.first_y;
  assign p1_in[2] = in_ch.first_z;
  assign p2_in[0] = in_ch.second_x;
  assign p2_in[1] = in_ch.second_y;
  assign p2_in[2] = in_ch.second_z;

  logic in_acc;
  logic cfg_acc;
  logic [W:0] den_in;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign den_in  = {p1_in[2][W-1], p1_in[2]} - {p2_in[2][W-1], p2_in[2]};

  // shared divider
  logic           div_start;
  logic           div_done;
  logic           div_ovf;
  logic [W+1:0]   div_q;
  assign div_start = (state_r == bewa_pkg::S_DIVS);

  bewa_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_r),
    .divisor  (dsr_r),
    .done     (div_done),
    .ovf      (div_ovf),
    .quo      (div_q)
  );

  // window bookkeeping
  logic [CNTW-1:0] depth_eff;
  logic [SLW-1:0]  slot_cur;
  logic [CNTW-1:0] slot_inc;
  logic [CNTW-1:0] count_cur;
  logic            pass_thru;
  assign depth_eff = (32'(depth_r) > MAX_WINDOW) ? CNTW'(MAX_WINDOW) : CNTW'(depth_r);
  assign pass_thru = (depth_eff < CNTW'(2));
  assign slot_cur  = (CNTW'(wslot_r) < depth_eff) ? wslot_r : '0;
  assign slot_inc  = CNTW'(slot_cur) + 1'b1;
  assign count_cur = full_r ? depth_eff : slot_inc;

  // signed quotient and extrapolated coordinate
  logic [W:0]    ud;
  logic [XW-1:0] q_ext;
  logic [XW-1:0] q_sgn;
  logic [XW-1:0] ext_sum;
  logic [W-1:0]  ext_val;
  logic [SW-1:0] sum_mag;
  logic [W-1:0]  old_k;
  assign ud      = den_r[W] ? (~den_r + 1'b1) : den_r;
  assign q_ext   = {2'b00, div_q};
  assign q_sgn   = neg_r ? (~q_ext + 1'b1) : q_ext;
  assign ext_sum = {{4{p2_r[k_r[1:0]][W-1]}}, p2_r[k_r[1:0]]} + q_sgn;
  assign ext_val = div_ovf ? (neg_r ? CMIN : CMAX) : sat_w(ext_sum);
  assign sum_mag = sums_r[k_r][SW-1] ? SW'(-sums_r[k_r]) : SW'(sums_r[k_r]);
  assign old_k   = rd_q_r[k_r*W +: W];

  // sequencer and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bewa_pkg::S_IDLE;
      k_r         <= '0;
      avg_r       <= 1'b0;
      depth_r     <= '0;
      wslot_r     <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < bewa_pkg::NUM_VAL; i++) sums_r[i] <= '0;
    end else begin
      // result register: set on handoff, cleared when taken
      if (state_r == bewa_pkg::S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        bewa_pkg::S_IDLE: begin
          if (cfg_acc) begin
            depth_r <= cfg_ch.window_depth;
            wslot_r <= '0;
            full_r  <= 1'b0;
            for (int i = 0; i < bewa_pkg::NUM_VAL; i++) sums_r[i] <= '0;
          end else if (in_acc) begin
            if (in_ch.kind) begin
              wslot_r <= '0;
              full_r  <= 1'b0;
              for (int i = 0; i < bewa_pkg::NUM_VAL; i++) sums_r[i] <= '0;
            end else begin
              k_r     <= '0;
              avg_r   <= 1'b0;
              state_r <= (den_in == '0) ? bewa_pkg::S_POST : bewa_pkg::S_MUL;
            end
          end
        end
        bewa_pkg::S_MUL:  state_r <= bewa_pkg::S_PREP;
        bewa_pkg::S_PREP: state_r <= bewa_pkg::S_DIVS;
        bewa_pkg::S_DIVS: state_r <= bewa_pkg::S_DIVW;
        bewa_pkg::S_DIVW: begin
          if (div_done) begin
            if (avg_r) begin
              if (k_r == 3'(bewa_pkg::NUM_VAL - 1)) state_r <= bewa_pkg::S_DONE;
              else begin
                k_r     <= k_r + 1'b1;
                state_r <= bewa_pkg::S_PREP;
              end
            end else begin
              if (k_r == 3'(bewa_pkg::NUM_AXES - 1)) state_r <= bewa_pkg::S_POST;
              else begin
                k_r     <= k_r + 1'b1;
                state_r <= bewa_pkg::S_MUL;
              end
            end
          end
        end
        bewa_pkg::S_POST: begin
          if (pass_thru) state_r <= bewa_pkg::S_DONE;
          else begin
            if (slot_inc >= depth_eff) begin
              wslot_r <= '0;
              full_r  <= 1'b1;
            end else begin
              wslot_r <= SLW'(slot_inc);
            end
            state_r <= bewa_pkg::S_RD;
          end
        end
        bewa_pkg::S_RD: state_r <= bewa_pkg::S_WR;
        bewa_pkg::S_WR: begin
          k_r     <= '0;
          state_r <= bewa_pkg::S_SUM;
        end
        bewa_pkg::S_SUM: begin
          // remove the oldest entry once full, add the new one
          sums_r[k_r] <= sums_r[k_r] + SW'($signed(val_r[k_r]))
                         - (was_full_r ? SW'($signed(old_k)) : SW'(0));
          if (k_r == 3'(bewa_pkg::NUM_VAL - 1)) begin
            k_r     <= '0;
            avg_r   <= 1'b1;
            state_r <= bewa_pkg::S_PREP;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        bewa_pkg::S_DONE: begin
          if (!out_valid_r || out_ch.ready) state_r <= bewa_pkg::S_IDLE;
        end
        default: state_r <= bewa_pkg::S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      bewa_pkg::S_IDLE: begin
        if (in_acc && !in_ch.kind) begin
          for (int i = 0; i < bewa_pkg::NUM_AXES; i++) begin
            p2_r[i]  <= p2_in[i];
            val_r[i] <= p2_in[i];
            val_r[i + bewa_pkg::NUM_AXES] <=
              sat_w({{4{p2_in[i][W-1]}}, p2_in[i]} - {{4{p1_in[i][W-1]}}, p1_in[i]});
          end
          den_r   <= den_in;
          degen_r <= (den_in == '0);
        end
      end
      bewa_pkg::S_MUL: begin
        prod_r <= (2*W)'(mag_w(p2_r[2])) * (2*W)'(mag_w(val_r[3'(bewa_pkg::NUM_AXES) + k_r]));
        neg_r  <= p2_r[2][W-1] ^ val_r[3'(bewa_pkg::NUM_AXES) + k_r][W-1] ^ den_r[W];
      end
      bewa_pkg::S_PREP: begin
        if (avg_r) begin
          dvd_r <= (2*W)'(sum_mag) + (2*W)'(cnt_r >> 1);
          dsr_r <= (W+1)'(cnt_r);
          neg_r <= sums_r[k_r][SW-1];
        end else begin
          dvd_r <= prod_r + (2*W)'(ud >> 1);
          dsr_r <= ud;
        end
      end
      bewa_pkg::S_DIVW: begin
        if (div_done) begin
          if (avg_r) res_r[k_r] <= q_sgn[W-1:0];
          else       val_r[k_r] <= ext_val;
        end
      end
      bewa_pkg::S_POST: begin
        if (pass_thru) begin
          for (int i = 0; i < bewa_pkg::NUM_VAL; i++) res_r[i] <= val_r[i];
          cnt_r <= CNTW'(1);
        end else begin
          slot_r     <= slot_cur;
          cnt_r      <= count_cur;
          was_full_r <= full_r;
        end
      end
      bewa_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          for (int i = 0; i < bewa_pkg::NUM_VAL; i++) out_r[i] <= res_r[i];
          out_degen_r <= degen_r;
          out_fill_r  <= FW'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  // ring memory: one wide row per slot
  always_ff @(posedge clk) begin
    if (state_r == bewa_pkg::S_RD) rd_q_r <= ring_mem[slot_r];
    if (state_r == bewa_pkg::S_WR) begin
      ring_mem[slot_r] <= {val_r[5], val_r[4], val_r[3], val_r[2], val_r[1], val_r[0]};
    end
  end

  // ports; a depth write takes the idle slot ahead of an item
  assign cfg_ch.ready      = (state_r == bewa_pkg::S_IDLE);
  assign in_ch.ready       = (state_r == bewa_pkg::S_IDLE) && !cfg_ch.valid;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.target_x   = out_r[0];
  assign out_ch.target_y   = out_r[1];
  assign out_ch.target_z   = out_r[2];
  assign out_ch.slope_x    = out_r[3];
  assign out_ch.slope_y    = out_r[4];
  assign out_ch.slope_z    = out_r[5];
  assign out_ch.degenerate = out_degen_r;
  assign out_ch.fill_count = out_fill_r;

  `BEWA_AP_NOW(a_busy_not_ready, (state_r != bewa_pkg::S_IDLE), !in_ch.ready, "ready while busy")
  `BEWA_AP_NEXT(a_sample_starts, (in_acc && !in_ch.kind), (state_r != bewa_pkg::S_IDLE), "sample ignored")
  `BEWA_AP_NOW(a_div_done_wait, div_done, (state_r == bewa_pkg::S_DIVW), "divider result unused")
  `BEWA_AP_NOW(a_full_window, full_r, (depth_eff >= CNTW'(2)), "full flag without window")

endmodule
